// File: rtl/core/imau_pkg.sv
package imau_pkg;

  localparam int DIM_W   = 4;
  localparam int IDX_W   = 6;
  localparam int DATA_W  = 32;
  localparam int PADDR_W = 5;

  // input item kinds
  localparam logic [1:0] KIND_WRITE_A = 2'd0;
  localparam logic [1:0] KIND_WRITE_B = 2'd1;
  localparam logic [1:0] KIND_START   = 2'd2;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_OPERATION = 3'd0;
  localparam logic [2:0] REG_A_ROWS    = 3'd1;
  localparam logic [2:0] REG_A_COLS    = 3'd2;
  localparam logic [2:0] REG_B_ROWS    = 3'd3;
  localparam logic [2:0] REG_B_COLS    = 3'd4;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_ERROR
  } state_t;

  typedef struct packed {
    logic [1:0]       op;
    logic [DIM_W-1:0] a_rows;
    logic [DIM_W-1:0] a_cols;
    logic [DIM_W-1:0] b_rows;
    logic [DIM_W-1:0] b_cols;
  } cfg_t;

  typedef struct packed {
    logic load;      // input beat taken this cycle
    logic clear;     // start of a run: zero counters
    logic issue;     // read one operand pair, step k
    logic emit;      // load result register, step to next element
    logic emit_err;  // load the error result
  } cmd_t;

  typedef struct packed {
    logic shape_ok;
    logic k_last;
    logic elem_last;
    logic acc_done;
    logic out_free;
  } sts_t;

endpackage

// File: rtl/core/imau_ctrl.sv
module imau_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [1:0]        kind,
  input  imau_pkg::sts_t    sts,
  output imau_pkg::cmd_t    cmd,
  output logic              in_stall
);
  import imau_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && kind == KIND_START) begin
          state_next = sts.shape_ok ? ST_ISSUE : ST_ERROR;
        end
      end
      ST_ISSUE: begin
        if (sts.k_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (sts.acc_done && sts.out_free) begin
          state_next = sts.elem_last ? ST_IDLE : ST_ISSUE;
        end
      end
      ST_ERROR: begin
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall  = 1'b0;
        cmd.load  = in_valid;
        cmd.clear = in_valid && kind == KIND_START && sts.shape_ok;
      end
      ST_ISSUE: cmd.issue = 1'b1;
      ST_DRAIN: cmd.emit = sts.acc_done && sts.out_free;
      ST_ERROR: cmd.emit_err = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// File: rtl/core/imau_dp.sv
module imau_dp #(
  parameter int MAX_DIM = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  imau_pkg::cfg_t                cfg,
  input  imau_pkg::cmd_t                cmd,
  output imau_pkg::sts_t                sts,
  input  logic [1:0]                    kind,
  input  logic [imau_pkg::IDX_W-1:0]    elem_index,
  input  logic signed [imau_pkg::DATA_W-1:0] elem_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [imau_pkg::IDX_W-1:0]    out_index,
  output logic signed [imau_pkg::DATA_W-1:0] out_value,
  output logic                          dim_error,
  output logic                          last
);
  import imau_pkg::*;

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CALC_W = 2 * DIM_W;
  localparam logic [IDX_W:0]   DEPTH_V = (IDX_W + 1)'(DEPTH);
  localparam logic [DIM_W-1:0] MAXD_V  = DIM_W'(MAX_DIM);

  logic [DATA_W-1:0] a_mem [DEPTH];
  logic [DATA_W-1:0] b_mem [DEPTH];

  logic [CW-1:0] row_i, col_j, k_cnt;

  logic              s1_valid, s1_first, s1_lastk;
  logic              s2_valid, s2_first, s2_lastk;
  logic [DATA_W-1:0] a_rd, b_rd, term, acc;
  logic              acc_done;

  logic              is_mul;
  logic [DIM_W-1:0]  cols, kmax_m1, rows_m1, cols_m1;
  logic [CALC_W-1:0] a_full, b_full, pos_full;
  logic              idx_ok, out_free, shape_ok, dims_ok;

  function automatic logic dim_ok(input logic [DIM_W-1:0] d);
    return d != '0 && d <= MAXD_V;
  endfunction

  assign is_mul  = cfg.op == OP_MUL;
  assign cols    = is_mul ? cfg.b_cols : cfg.a_cols;
  assign rows_m1 = cfg.a_rows - DIM_W'(1);
  assign cols_m1 = cols - DIM_W'(1);
  assign kmax_m1 = is_mul ? cfg.a_cols - DIM_W'(1) : '0;

  assign dims_ok = dim_ok(cfg.a_rows) && dim_ok(cfg.a_cols) &&
                   dim_ok(cfg.b_rows) && dim_ok(cfg.b_cols);

  always_comb begin
    case (cfg.op)
      OP_ADD, OP_SUB:
        shape_ok = dims_ok && cfg.a_rows == cfg.b_rows && cfg.a_cols == cfg.b_cols;
      OP_MUL:  shape_ok = dims_ok && cfg.a_cols == cfg.b_rows;
      default: shape_ok = 1'b0;
    endcase
  end

  // A[i][k] and B[k][j] for multiply, both at element (i,j) otherwise
  assign a_full = CALC_W'(row_i) * CALC_W'(cfg.a_cols) +
                  CALC_W'(is_mul ? k_cnt : col_j);
  assign b_full = is_mul ? CALC_W'(k_cnt) * CALC_W'(cfg.b_cols) + CALC_W'(col_j)
                         : a_full;
  assign pos_full = CALC_W'(row_i) * CALC_W'(cols) + CALC_W'(col_j);

  assign idx_ok   = {1'b0, elem_index} < DEPTH_V;
  assign out_free = !out_valid || !out_stall;

  assign sts.shape_ok  = shape_ok;
  assign sts.k_last    = DIM_W'(k_cnt) == kmax_m1;
  assign sts.elem_last = DIM_W'(row_i) == rows_m1 && DIM_W'(col_j) == cols_m1;
  assign sts.acc_done  = acc_done;
  assign sts.out_free  = out_free;

  // stores: one write port, registered read
  always_ff @(posedge clk) begin
    if (cmd.load && idx_ok && kind == KIND_WRITE_A) begin
      a_mem[elem_index[AW-1:0]] <= elem_value;
    end
    if (cmd.load && idx_ok && kind == KIND_WRITE_B) begin
      b_mem[elem_index[AW-1:0]] <= elem_value;
    end
    a_rd <= a_mem[a_full[AW-1:0]];
    b_rd <= b_mem[b_full[AW-1:0]];
  end

  // loop counters
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      row_i <= '0;
      col_j <= '0;
      k_cnt <= '0;
    end else begin
      if (cmd.issue) begin
        k_cnt <= sts.k_last ? '0 : k_cnt + CW'(1);
      end
      if (cmd.emit) begin
        if (DIM_W'(col_j) == cols_m1) begin
          col_j <= '0;
          row_i <= row_i + CW'(1);
        end else begin
          col_j <= col_j + CW'(1);
        end
      end
    end
  end

  // read -> term -> accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      acc_done <= 1'b0;
    end else begin
      s1_valid <= cmd.issue;
      s2_valid <= s1_valid;
      if (cmd.issue || cmd.clear) begin
        acc_done <= 1'b0;
      end else if (s2_valid && s2_lastk) begin
        acc_done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_first <= k_cnt == '0;
    s1_lastk <= sts.k_last;
    s2_first <= s1_first;
    s2_lastk <= s1_lastk;
    case (cfg.op)
      OP_SUB:  term <= a_rd - b_rd;
      OP_MUL:  term <= a_rd * b_rd;
      default: term <= a_rd + b_rd;
    endcase
    if (s2_valid) begin
      acc <= s2_first ? term : acc + term;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit || cmd.emit_err) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_index <= pos_full[IDX_W-1:0];
      out_value <= acc;
      dim_error <= 1'b0;
      last      <= sts.elem_last;
    end else if (cmd.emit_err) begin
      out_index <= '0;
      out_value <= '0;
      dim_error <= 1'b1;
      last      <= 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit || cmd.emit_err) |-> out_free)
    else $error("result loaded over an untaken beat");

  a_emit_drained: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (acc_done && !s1_valid && !s2_valid))
    else $error("result emitted before accumulation finished");

  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && dim_error) |-> (last && out_index == '0 && out_value == '0))
    else $error("malformed error result");
`endif

endmodule

// File: rtl/core/integer_matrix_arith_unit.sv
// Channel  Dir  Handshake            Payload
// in       in   in_valid/in_stall    kind, elem_index, elem_value
// out      out  out_valid/out_stall  out_index, out_value, dim_error, last
// cfg      in   APB psel/penable     paddr (5b), pwdata/prdata (32b), pready tied high
//
// Element writes are taken one per cycle; in_stall is low only while no run is active.
// Each result element reads K operand pairs (K = a_cols for multiply, 1 otherwise);
// the store read, term and accumulate stages of one element are not overlapped with the next.
// A shape error enters the error state, which loads its single beat once the output is free.
// out_stall holds the result register and pauses the run; rst is synchronous and clears
// control state and the registers to their defaults; store contents are not cleared.
module integer_matrix_arith_unit #(
  parameter int MAX_DIM = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        kind,
  input  logic [imau_pkg::IDX_W-1:0]        elem_index,
  input  logic signed [imau_pkg::DATA_W-1:0] elem_value,
  // output channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [imau_pkg::IDX_W-1:0]        out_index,
  output logic signed [imau_pkg::DATA_W-1:0] out_value,
  output logic                              dim_error,
  output logic                              last,
  // register port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [imau_pkg::PADDR_W-1:0]      paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import imau_pkg::*;

  cfg_t       cfg;
  cmd_t       cmd;
  sts_t       sts;
  logic       wr_en;
  logic [2:0] reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[PADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  // Registers; indexes past the last register are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.op     <= OP_ADD;
      cfg.a_rows <= DIM_W'(1);
      cfg.a_cols <= DIM_W'(1);
      cfg.b_rows <= DIM_W'(1);
      cfg.b_cols <= DIM_W'(1);
    end else if (wr_en) begin
      case (reg_sel)
        REG_OPERATION: cfg.op     <= pwdata[1:0];
        REG_A_ROWS:    cfg.a_rows <= pwdata[DIM_W-1:0];
        REG_A_COLS:    cfg.a_cols <= pwdata[DIM_W-1:0];
        REG_B_ROWS:    cfg.b_rows <= pwdata[DIM_W-1:0];
        REG_B_COLS:    cfg.b_cols <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_OPERATION: prdata = 32'(cfg.op);
      REG_A_ROWS:    prdata = 32'(cfg.a_rows);
      REG_A_COLS:    prdata = 32'(cfg.a_cols);
      REG_B_ROWS:    prdata = 32'(cfg.b_rows);
      REG_B_COLS:    prdata = 32'(cfg.b_cols);
      default:       prdata = '0;
    endcase
  end

  // Sequencer: walks element, then k, and waits on the result register.
  imau_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .kind     (kind),
    .sts      (sts),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  // Stores, counters, multiply/accumulate and result register.
  imau_dp #(
    .MAX_DIM (MAX_DIM)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cmd        (cmd),
    .sts        (sts),
    .kind       (kind),
    .elem_index (elem_index),
    .elem_value (elem_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_index  (out_index),
    .out_value  (out_value),
    .dim_error  (dim_error),
    .last       (last)
  );

`ifndef SYNTHESIS
  a_start_blocks: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && kind == KIND_START) |=> in_stall)
    else $error("input not held off after a start beat");
`endif

endmodule

// File: bench/integer_matrix_arith_unit_tb.sv
module integer_matrix_arith_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import imau_pkg::*;

  localparam int MAX_DIM      = 8;
  localparam int DEPTH        = MAX_DIM * MAX_DIM;
  localparam int RANDOM_ITEMS = 125;
  localparam int RUN_TAIL     = 16;    // quiet cycles after the last result before a reg write
  localparam int IDLE_LIMIT   = 4000;  // cycles with no beat on any port before giving up
  localparam int REPORT_MAX   = 10;

  // codes the package does not name
  localparam logic [1:0] KIND_NONE    = 2'd3;  // unused kind, dropped by the block
  localparam logic [1:0] OP_NONE      = 2'd3;  // unused operation, always a shape error
  localparam logic [2:0] REG_SPARE_LO = 3'd5;  // first unmapped register slot
  localparam logic [2:0] REG_SPARE_HI = 3'd7;  // last unmapped register slot

  // one result beat as the block should present it
  typedef struct {
    logic [IDX_W-1:0]  pos;
    logic [DATA_W-1:0] val;
    logic              err;
    logic              lst;
  } elem_t;

  // Mirrors the stores and the registers, turns every start beat into the
  // expected result matrix and checks result beats against it in order.
  class matrix_board;
    logic [1:0]        op;
    logic [DIM_W-1:0]  a_rows, a_cols, b_rows, b_cols;
    logic [DATA_W-1:0] a_mem [DEPTH];
    logic [DATA_W-1:0] b_mem [DEPTH];
    elem_t             pending [$];
    int                mismatches;
    int                results_seen;
    int                error_runs;
    int                good_runs;

    function new();
      op     = OP_ADD;
      a_rows = 1;
      a_cols = 1;
      b_rows = 1;
      b_cols = 1;
      foreach (a_mem[i]) begin
        a_mem[i] = '0;
        b_mem[i] = '0;
      end
    endfunction

    function void write_reg(logic [2:0] r, logic [31:0] d);
      case (r)
        REG_OPERATION: op     = d[1:0];
        REG_A_ROWS:    a_rows = d[DIM_W-1:0];
        REG_A_COLS:    a_cols = d[DIM_W-1:0];
        REG_B_ROWS:    b_rows = d[DIM_W-1:0];
        REG_B_COLS:    b_cols = d[DIM_W-1:0];
        default: ;
      endcase
    endfunction

    function bit dim_fits(logic [DIM_W-1:0] d);
      return d >= 1 && d <= MAX_DIM;
    endfunction

    function bit shape_fits();
      bit dims;
      dims = dim_fits(a_rows) && dim_fits(a_cols) && dim_fits(b_rows) && dim_fits(b_cols);
      if (op == OP_ADD || op == OP_SUB)
        return dims && a_rows == b_rows && a_cols == b_cols;
      if (op == OP_MUL)
        return dims && a_cols == b_rows;
      return 1'b0;
    endfunction

    function void predict_run();
      elem_t             e;
      int                rows, cols, total, pos;
      logic [DATA_W-1:0] acc;
      if (!shape_fits()) begin
        e.pos = '0;
        e.val = '0;
        e.err = 1'b1;
        e.lst = 1'b1;
        pending.push_back(e);
        error_runs++;
        return;
      end
      rows  = a_rows;
      cols  = (op == OP_MUL) ? b_cols : a_cols;
      total = rows * cols;
      for (int i = 0; i < rows; i++) begin
        for (int j = 0; j < cols; j++) begin
          pos = i * cols + j;
          if (op == OP_MUL) begin
            acc = '0;
            for (int k = 0; k < a_cols; k++)
              acc = acc + a_mem[i * a_cols + k] * b_mem[k * cols + j];
          end else if (op == OP_ADD) begin
            acc = a_mem[pos] + b_mem[pos];
          end else begin
            acc = a_mem[pos] - b_mem[pos];
          end
          e.pos = pos[IDX_W-1:0];
          e.val = acc;
          e.err = 1'b0;
          e.lst = (pos == total - 1);
          pending.push_back(e);
        end
      end
      good_runs++;
    endfunction

    // accepted input beat
    function void note_beat(logic [1:0] k, logic [IDX_W-1:0] idx, logic [DATA_W-1:0] v);
      case (k)
        KIND_WRITE_A: a_mem[idx] = v;
        KIND_WRITE_B: b_mem[idx] = v;
        KIND_START:   predict_run();
        default: ;
      endcase
    endfunction

    // accepted result beat
    function void check_beat(logic [IDX_W-1:0] pos, logic [DATA_W-1:0] val,
                             logic err, logic lst);
      elem_t e;
      results_seen++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: result beat with nothing outstanding: idx %0d val %h err %b last %b",
                   $time, pos, val, err, lst);
        return;
      end
      e = pending.pop_front();
      if (e.pos !== pos || e.val !== val || e.err !== err || e.lst !== lst) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("%0t: result mismatch: exp idx %0d val %h err %b last %b",
                   $time, e.pos, e.val, e.err, e.lst);
          $display("%0t:                  got idx %0d val %h err %b last %b",
                   $time, pos, val, err, lst);
        end
      end
    endfunction
  endclass

  logic                clk;
  logic                rst        = 1'b1;
  logic                in_valid   = 1'b0;
  logic                in_stall;
  logic [1:0]          kind       = KIND_WRITE_A;
  logic [IDX_W-1:0]    elem_index = '0;
  logic [DATA_W-1:0]   elem_value = '0;
  logic                out_valid;
  logic                out_stall  = 1'b0;
  logic [IDX_W-1:0]    out_index;
  logic [DATA_W-1:0]   out_value;
  logic                dim_error;
  logic                last;
  logic                psel       = 1'b0;
  logic                penable    = 1'b0;
  logic                pwrite     = 1'b0;
  logic [PADDR_W-1:0]  paddr      = '0;
  logic [31:0]         pwdata     = '0;
  logic [31:0]         prdata;
  logic                pready;

  matrix_board board;
  bit          a_set [DEPTH];   // entries loaded since reset; starts never read others
  bit          b_set [DEPTH];
  bit          no_idle;         // sender runs flat out for the current setting
  int          item_count;      // load and start beats accepted
  int          settings;        // register settings applied
  int          stall_hold;
  int          stall_roll;
  int          idle_cycles;

  integer_matrix_arith_unit #(.MAX_DIM(MAX_DIM)) uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .elem_index (elem_index),
    .elem_value (elem_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_index  (out_index),
    .out_value  (out_value),
    .dim_error  (dim_error),
    .last       (last),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver back-pressure: free stretches, short stalls and the odd long one,
  // so stalls land on every stage of a run and on the error beat.
  always @(posedge clk) begin
    if (stall_hold > 0) begin
      stall_hold--;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 50) begin
        out_stall <= 1'b0;
        stall_hold = $urandom_range(0, 24);
      end else if (stall_roll < 92) begin
        out_stall <= 1'b1;
        stall_hold = $urandom_range(0, 2);
      end else begin
        out_stall <= 1'b1;
        stall_hold = $urandom_range(10, 40);
      end
    end
  end

  // result beats are checked on the edge that takes them
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.check_beat(out_index, out_value, dim_error, last);
  end

  // Watchdog: any beat on input, output or register port restarts the count.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (psel && penable && pready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d results outstanding",
               $time, IDLE_LIMIT, board.pending.size());
      $display("FAILURE");
      $finish;
    end
  end

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60)
      return 0;
    if (r < 93)
      return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // element values lean on the wrap points
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'($urandom_range(0, 3));
      default: return 32'($urandom);
    endcase
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0)
      return 4'(MAX_DIM);
    if (r == 1)
      return 4'($urandom_range(4, MAX_DIM - 1));
    return 4'($urandom_range(1, 3));
  endfunction

  // One input beat. Valid stays up after acceptance so the next call can
  // follow on the very next edge; a gap lowers it first.
  task automatic push_item(logic [1:0] k, logic [IDX_W-1:0] idx, logic [DATA_W-1:0] v);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    kind       <= k;
    elem_index <= idx;
    elem_value <= v;
    do @(posedge clk); while (in_stall);
    board.note_beat(k, idx, v);
    if (k != KIND_NONE)
      item_count++;
  endtask

  task automatic load_elem(bit to_b, logic [IDX_W-1:0] idx, logic [DATA_W-1:0] v);
    push_item(to_b ? KIND_WRITE_B : KIND_WRITE_A, idx, v);
    if (to_b)
      b_set[idx] = 1'b1;
    else
      a_set[idx] = 1'b1;
  endtask

  // noise: a dropped kind or a load anywhere in either store
  task automatic stray_beat();
    int r;
    r = $urandom_range(0, 5);
    if (r == 0)
      push_item(KIND_NONE, 6'($urandom), 32'($urandom));
    else
      load_elem(r > 2, 6'($urandom), pick_value());
  endtask

  // APB write: setup, then access; taken on the edge with pready high
  task automatic cfg_write(logic [2:0] r, logic [31:0] d);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= d;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.write_reg(r, d);
  endtask

  // Let the current run finish, plus a margin for a trailing write, before
  // touching the registers.
  task automatic settle();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (RUN_TAIL) @(posedge clk);
  endtask

  // All five registers; half the time with junk in the unused upper bits.
  task automatic apply_setting(logic [1:0] o, logic [DIM_W-1:0] ar, logic [DIM_W-1:0] ac,
                               logic [DIM_W-1:0] br, logic [DIM_W-1:0] bc);
    bit noisy;
    settle();
    noisy = $urandom_range(0, 1);
    cfg_write(REG_OPERATION, {noisy ? 30'($urandom) : 30'd0, o});
    cfg_write(REG_A_ROWS,    {noisy ? 28'($urandom) : 28'd0, ar});
    cfg_write(REG_A_COLS,    {noisy ? 28'($urandom) : 28'd0, ac});
    cfg_write(REG_B_ROWS,    {noisy ? 28'($urandom) : 28'd0, br});
    cfg_write(REG_B_COLS,    {noisy ? 28'($urandom) : 28'd0, bc});
    settings++;
  endtask

  task automatic random_setting();
    logic [1:0]       o;
    logic [DIM_W-1:0] ar, ac, br, bc;
    o  = ($urandom_range(0, 9) == 0) ? OP_NONE : 2'($urandom_range(0, 2));
    ar = pick_dim();
    ac = pick_dim();
    if (o == OP_MUL) begin
      br = ac;
      bc = pick_dim();
    end else begin
      br = ar;
      bc = ac;
    end
    // about one in five settings is broken on purpose
    if ($urandom_range(0, 4) == 0) begin
      case ($urandom_range(0, 2))
        0:       ar = 4'($urandom_range(MAX_DIM + 1, 15));
        1:       bc = '0;
        default: br = br + 1'b1;
      endcase
    end
    apply_setting(o, ar, ac, br, bc);
  endtask

  // One run: if the shape fits, make sure every entry the run reads holds data,
  // refresh a random share of the rest, sprinkle noise, then start.
  task automatic load_and_start();
    int need_a, need_b, keep;
    need_a = 0;
    need_b = 0;
    if (board.shape_fits()) begin
      need_a = board.a_rows * board.a_cols;
      need_b = board.b_rows * board.b_cols;
    end
    keep = $urandom_range(20, 90);
    for (int n = 0; n < need_a; n++) begin
      if (!a_set[n] || $urandom_range(0, 99) >= keep)
        load_elem(1'b0, 6'(n), pick_value());
      if ($urandom_range(0, 19) == 0)
        stray_beat();
    end
    for (int n = 0; n < need_b; n++) begin
      if (!b_set[n] || $urandom_range(0, 99) >= keep)
        load_elem(1'b1, 6'(n), pick_value());
      if ($urandom_range(0, 19) == 0)
        stray_beat();
    end
    if (need_a == 0)
      repeat ($urandom_range(0, 3)) stray_beat();
    push_item(KIND_START, 6'($urandom), 32'($urandom));
    // now and then start again straight away on the same stores
    if ($urandom_range(0, 7) == 0)
      push_item(KIND_START, 6'($urandom), 32'($urandom));
  endtask

  initial begin
    int rand_base;
    int phase;
    board = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // --- directed ---
    // reset setting is add on 1x1: dropped kind, top index, positive wrap,
    // then a repeated start
    push_item(KIND_NONE, 6'd63, 32'hFFFF_FFFF);
    load_elem(1'b0, 6'd63, 32'hFFFF_FFFF);
    load_elem(1'b1, 6'd63, 32'h8000_0000);
    load_elem(1'b0, 6'd0, 32'h7FFF_FFFF);
    load_elem(1'b1, 6'd0, 32'h0000_0001);
    push_item(KIND_START, 6'd0, 32'd0);
    push_item(KIND_START, 6'h3F, 32'hFFFF_FFFF);

    // subtract wrapping negative; writes to unmapped slots must change nothing
    apply_setting(OP_SUB, 4'd1, 4'd1, 4'd1, 4'd1);
    cfg_write(REG_SPARE_LO, 32'hFFFF_FFFF);
    cfg_write(REG_SPARE_HI, 32'h0000_0002);
    load_elem(1'b0, 6'd0, 32'h8000_0000);
    push_item(KIND_START, 6'($urandom), 32'($urandom));

    // outer product 2x1 * 1x2
    apply_setting(OP_MUL, 4'd2, 4'd1, 4'd1, 4'd2);
    load_elem(1'b0, 6'd1, 32'h0000_0003);
    load_elem(1'b1, 6'd1, 32'hFFFF_FFFF);
    push_item(KIND_START, 6'($urandom), 32'($urandom));

    // shape errors: unused op, zero dim, oversized dim, add mismatch,
    // multiply mismatch, multiply with matching but oversized inner dim
    apply_setting(OP_NONE, 4'd1, 4'd1, 4'd1, 4'd1);
    push_item(KIND_START, 6'($urandom), 32'($urandom));
    apply_setting(OP_ADD, 4'd0, 4'd1, 4'd0, 4'd1);
    push_item(KIND_START, 6'($urandom), 32'($urandom));
    apply_setting(OP_SUB, 4'd1, 4'd15, 4'd1, 4'd15);
    push_item(KIND_START, 6'($urandom), 32'($urandom));
    apply_setting(OP_ADD, 4'd2, 4'd1, 4'd1, 4'd2);
    push_item(KIND_START, 6'($urandom), 32'($urandom));
    apply_setting(OP_MUL, 4'd2, 4'd2, 4'd1, 4'd2);
    push_item(KIND_START, 6'($urandom), 32'($urandom));
    apply_setting(OP_MUL, 4'd1, 4'd9, 4'd9, 4'd1);
    push_item(KIND_START, 6'($urandom), 32'($urandom));

    // --- random ---
    // the first two settings pin every dimension register at its maximum:
    // 8x1 * 1x8 gives the full 64-beat result, 1x8 * 8x1 the deepest sum
    rand_base = item_count;
    phase = 0;
    while (item_count - rand_base < RANDOM_ITEMS) begin
      if (phase == 0)
        apply_setting(OP_MUL, 4'(MAX_DIM), 4'd1, 4'd1, 4'(MAX_DIM));
      else if (phase == 1)
        apply_setting(OP_MUL, 4'd1, 4'(MAX_DIM), 4'(MAX_DIM), 4'd1);
      else
        random_setting();
      no_idle = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(1, 3)) load_and_start();
      phase++;
    end
    no_idle = 1'b0;

    settle();
    $display("covered %0d load/start beats over %0d register settings", item_count, settings);
    $display("%0d result beats from %0d computed runs and %0d shape errors, %0d mismatches",
             board.results_seen, board.good_runs, board.error_runs, board.mismatches);
    if (board.mismatches == 0 && board.pending.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
